>>> src/lru_page_replacement_macros.svh
// Assertion macros for the LRU page replacement block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lru_pkg.sv
// Shared types and constants for the LRU page replacement block.
// Used by lru_cell and lru_page_replacement; depends on nothing.
package lru_pkg;

    localparam int COUNT_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int FIU_W     = 5;
    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
    localparam int PAGE_IN_W = 16;

    // Control that the top level hands to every stack cell.
    typedef struct packed {
        logic accept;   // a reference word is taken this cycle
        logic active;   // the cell lies inside the active depth
        logic clear;    // a depth write drops this cell out of use
    } cell_ctrl_t;

endpackage

>>> src/lru_cell.sv
// One position of the LRU recency stack: a stored page and its valid bit.
// Depends on lru_pkg for the control struct.
module lru_cell #(
    parameter int PAGE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lru_pkg::cell_ctrl_t    ctrl,
    input  logic [PAGE_BITS-1:0]   cmp_page,
    input  logic [PAGE_BITS-1:0]   up_page,
    input  logic                   up_valid,
    input  logic                   found_in,
    output logic [PAGE_BITS-1:0]   page_out,
    output logic                   valid_out,
    output logic                   found_out
);

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 match;
    logic                 shift;

    assign match     = ctrl.active && valid_reg && (page_reg == cmp_page);
    assign found_out = found_in || match;
    // Every cell from the top down to the matching one (or the bottom of
    // the active depth on a miss) takes its upper neighbor's contents.
    assign shift     = ctrl.accept && ctrl.active && !found_in;

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            page_next  = up_page;
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            page_reg  <= page_next;
            valid_reg <= valid_next;
        end
    end

    assign page_out  = page_reg;
    assign valid_out = valid_reg;

endmodule

>>> src/lru_page_replacement.sv
// LRU page replacement stack: top level with the cell chain and counters.
// Depends on lru_pkg, lru_cell and lru_page_replacement_macros.svh.
//
// Use: each input word on the in channel (in_valid, in_stall, page_number)
// is one page reference. The block searches a chain of FRAMES cells that
// hold the resident pages, most recent first, and rebuilds the order in the
// same cycle: on a hit the page moves to the top and the cells above its old
// place shift down one; on a miss every cell in the active depth shifts down,
// the bottom page drops out and the new page enters at the top.
// Each reference yields one output word on the out channel (out_valid,
// out_stall, hit, access_count, miss_count). The two counters saturate at
// their all-ones value.
// An accepted word appears at the output register in the next cycle.
// Throughput is one reference per cycle unless out_stall holds a pending
// word, set by the chain's compare and shift and the one output stage.
// While the receiver holds out_stall with a word pending, in_stall is raised
// and the stack does not move; the pending word stays unchanged.
// The depth register is written through cfg_we and cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. Zero acts as
// one, above FRAMES as FRAMES; a write empties cells at or beyond the new depth.
// Reset empties the stack, clears both counters, sets the depth to 16 and
// leaves the output channel empty.
module lru_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lru_pkg::PAGE_IN_W-1:0]     page_number,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [lru_pkg::COUNT_W-1:0]       access_count,
    output logic [lru_pkg::COUNT_W-1:0]       miss_count,
    input  logic                              cfg_we,
    input  logic [lru_pkg::FIU_W-1:0]         cfg_wdata
);

`include "lru_page_replacement_macros.svh"

    // Cell indexes reach FRAMES-1; the depth register is five bits wide.
    localparam int DEPTH_W = $clog2(FRAMES + 1);
    localparam int CMP_W   = (DEPTH_W > lru_pkg::FIU_W) ? DEPTH_W : lru_pkg::FIU_W;
    localparam logic [lru_pkg::COUNT_W-1:0] COUNT_STEP = {{(lru_pkg::COUNT_W-1){1'b0}}, 1'b1};

    logic [lru_pkg::FIU_W-1:0]   frames_reg;
    logic [lru_pkg::COUNT_W-1:0] acc_cnt_reg;
    logic [lru_pkg::COUNT_W-1:0] acc_cnt_next;
    logic [lru_pkg::COUNT_W-1:0] miss_cnt_reg;
    logic [lru_pkg::COUNT_W-1:0] miss_cnt_next;
    logic                        out_valid_reg;
    logic                        hit_reg;
    logic                        accept;
    logic [PAGE_BITS-1:0]        page;
    logic [CMP_W-1:0]            depth_cur;
    logic [CMP_W-1:0]            depth_new;
    logic                        ref_hit;

    // Chain wires: index i feeds cell i from above; index FRAMES is the end.
    logic [PAGE_BITS-1:0]        chain_page  [FRAMES+1];
    logic [FRAMES:0]             chain_valid;
    logic [FRAMES:0]             chain_found;

    // Only the low PAGE_BITS of a reference count; wider builds zero-extend.
    generate
        if (PAGE_BITS <= lru_pkg::PAGE_IN_W)
        begin : g_page_trunc
            assign page = page_number[PAGE_BITS-1:0];
        end
        else
        begin : g_page_ext
            assign page = {{(PAGE_BITS - lru_pkg::PAGE_IN_W){1'b0}}, page_number};
        end
    endgenerate

    // A new word may enter unless the output register holds a stalled word.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign depth_cur = CMP_W'(frames_reg);
    assign depth_new = CMP_W'(cfg_wdata);

    // The top cell is fed the new reference, marked valid.
    assign chain_page[0]  = page;
    assign chain_valid[0] = 1'b1;
    assign chain_found[0] = 1'b0;

    generate
        for (genvar i = 0; i < FRAMES; i++)
        begin : g_cell
            localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
            lru_pkg::cell_ctrl_t ctrl;

            // Cell zero is always in use, which folds in the depth-of-zero
            // case; comparing against the index folds in the upper clamp.
            assign ctrl.accept = accept;
            assign ctrl.active = (i == 0) || (depth_cur > IDX);
            assign ctrl.clear  = cfg_we && !((i == 0) || (depth_new > IDX));

            lru_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .cmp_page  (page),
                .up_page   (chain_page[i]),
                .up_valid  (chain_valid[i]),
                .found_in  (chain_found[i]),
                .page_out  (chain_page[i+1]),
                .valid_out (chain_valid[i+1]),
                .found_out (chain_found[i+1])
            );
        end
    endgenerate

    assign ref_hit = chain_found[FRAMES];

    always_comb
    begin
        acc_cnt_next  = acc_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (accept)
        begin
            if (acc_cnt_reg != lru_pkg::COUNT_MAX)
            begin
                acc_cnt_next = acc_cnt_reg + COUNT_STEP;
            end
            if (!ref_hit && (miss_cnt_reg != lru_pkg::COUNT_MAX))
            begin
                miss_cnt_next = miss_cnt_reg + COUNT_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= lru_pkg::FIU_RESET;
            acc_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_reg <= cfg_wdata;
            end
            acc_cnt_reg  <= acc_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The hit flag is payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg <= ref_hit;
        end
    end

    // The counters change only on an accepted word, so they serve directly
    // as the output payload and hold while the receiver stalls.
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign access_count = acc_cnt_reg;
    assign miss_count   = miss_cnt_reg;

    `LRU_ASSERT_NOW(a_stall_guard, out_valid_reg && out_stall, in_stall, "accept while output stalled")
    `LRU_ASSERT_NOW(a_miss_le_acc, 1'b1, miss_cnt_reg <= acc_cnt_reg, "miss count above access count")
    `LRU_ASSERT_NEXT(a_out_after_accept, accept, out_valid_reg, "accepted word produced no output")
    `LRU_ASSERT_NEXT(a_top_valid, accept && !cfg_we, chain_valid[1] && (chain_page[1] == $past(page)), "referenced page not at stack top")

endmodule
